/* design/rsp_pkg.sv */
// shared types, constants and helpers for the road segment projector
package rsp_pkg;

  localparam int MaxDrawSegmentsDefault = 512;

  localparam logic [12:0] RST_SCREEN_WIDTH   = 13'd1024;
  localparam logic [12:0] RST_SCREEN_HEIGHT  = 13'd768;
  localparam logic [15:0] RST_ROAD_WIDTH     = 16'd2000;
  localparam logic [11:0] RST_SEGMENT_LENGTH = 12'd200;
  localparam logic [15:0] RST_CAMERA_DEPTH   = 16'd215;

  localparam logic [23:0] SCALE_MAX   = 24'hFFFFFF;
  localparam logic [16:0] THIRD_RECIP = 17'd43691;

  typedef enum logic [2:0] {
    CFG_SCREEN_WIDTH   = 3'd0,
    CFG_SCREEN_HEIGHT  = 3'd1,
    CFG_ROAD_WIDTH     = 3'd2,
    CFG_SEGMENT_LENGTH = 3'd3,
    CFG_CAMERA_DEPTH   = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    OP_FRAME   = 1'b0,
    OP_SEGMENT = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRAME,
    ST_DEN,
    ST_DIV_INIT,
    ST_DIV,
    ST_SAT,
    ST_X1,
    ST_X2,
    ST_Y1,
    ST_Y2,
    ST_H1,
    ST_H2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               operation;
    logic signed [23:0] camera_x;
    logic signed [23:0] camera_height;
    logic signed [23:0] segment_height;
    logic signed [11:0] segment_curve;
    logic        [15:0] segment_index;
  } in_data_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic        [15:0] half_width;
    logic signed [15:0] prev_x;
    logic signed [15:0] prev_y;
    logic        [15:0] prev_half_width;
    logic        [12:0] clip_y;
    logic               stripe;
  } out_data_t;

  typedef struct packed {
    logic               operation;
    logic signed [23:0] camera_x;
    logic signed [23:0] camera_height;
    logic signed [23:0] segment_height;
    logic signed [11:0] segment_curve;
    logic               stripe;
  } rsp_item_t;

  typedef struct packed {
    logic      valid;
    rsp_item_t item;
  } rsp_queue_t;

  function automatic logic signed [15:0] sat16(input logic signed [50:0] v);
    logic signed [15:0] r;
    if (v > 51'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -51'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

/* design/rsp_front.sv */
// input side: accepts items, derives stripe parity and queues them for the back end
module rsp_front
  import rsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_data_t   in_data,
  output rsp_queue_t q,
  input  logic       q_pop
);

  rsp_item_t   entry_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  count_r;
  logic        push;
  logic [32:0] third_prod;
  logic [15:0] third_quo;
  rsp_item_t   item_in;

  // index / 3 by reciprocal multiply, exact over 16 bits
  assign third_prod = 33'(in_data.segment_index) * 33'(THIRD_RECIP);
  assign third_quo  = third_prod[32:17];

  always_comb begin
    item_in.operation      = in_data.operation;
    item_in.camera_x       = in_data.camera_x;
    item_in.camera_height  = in_data.camera_height;
    item_in.segment_height = in_data.segment_height;
    item_in.segment_curve  = in_data.segment_curve;
    item_in.stripe         = third_quo[0];
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q.valid  = (count_r != 2'd0);
  assign q.item   = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(q_pop);
    end
  end

endmodule

/* design/rsp_back.sv */
// back end: sequencer with shared multiplier and radix-2 divider, road state, output register
module rsp_back
  import rsp_pkg::*;
#(
  parameter int MAX_DRAW_SEGMENTS = MaxDrawSegmentsDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data,
  input  rsp_queue_t q,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_data_t  out_data
);

  localparam logic [12:0] MaxDraw = 13'(MAX_DRAW_SEGMENTS);

  state_t state_r, state_nxt;

  logic [12:0] sw_r, sh_r;
  logic [15:0] rw_r, cd_r;
  logic [11:0] sl_r;

  rsp_item_t          item_r;
  logic signed [23:0] cam_x_r, cam_h_r;
  logic signed [31:0] lat_off_r, lat_step_r;
  logic [12:0]        horizon_r, depth_r;
  logic signed [15:0] last_x_r, last_y_r;
  logic [15:0]        last_hw_r;

  logic signed [50:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [75:0] prod_r;

  logic [24:0] den_r, rem_r;
  logic [31:0] quo_r;
  logic [4:0]  cnt_r;
  logic [23:0] sc_r;
  logic [25:0] rem_sh;
  logic        rem_ge;

  logic signed [15:0] x_r, y_r;
  logic [15:0]        hw;
  logic               vis;
  logic               out_load;
  logic               out_valid_r;
  out_data_t          out_data_r;
  logic signed [32:0] off_sum, step_sum;
  logic signed [25:0] dy;
  logic signed [50:0] diff;

  assign off_sum  = 33'(lat_off_r) + 33'(lat_step_r);
  assign step_sum = 33'(lat_step_r) + 33'(item_r.segment_curve);
  assign dy       = 26'(item_r.segment_height) - 26'(cam_h_r);
  assign diff     = 51'(lat_off_r) - (51'(cam_x_r) <<< 8);
  assign rem_sh   = {rem_r, quo_r[31]};
  assign rem_ge   = rem_sh >= {1'b0, den_r};
  assign hw       = (prod_r[75:41] != '0) ? 16'hFFFF : prod_r[40:25];
  assign vis      = (depth_r != '0) && (depth_r < MaxDraw) &&
                    ($signed({y_r[15], y_r}) < $signed({4'b0, horizon_r}));

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    case (state_r)
      ST_IDLE: begin
        if (q.valid) begin
          q_pop     = 1'b1;
          state_nxt = (q.item.operation == OP_SEGMENT) ? ST_DEN : ST_FRAME;
        end
      end
      ST_FRAME: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_DEN: begin
        mul_a     = $signed({38'b0, depth_r});
        mul_b     = $signed({13'b0, sl_r});
        state_nxt = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        state_nxt = (prod_r[24:0] == '0) ? ST_X1 : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == 5'd31) begin
          state_nxt = ST_SAT;
        end
      end
      ST_SAT: begin
        state_nxt = ST_X1;
      end
      ST_X1: begin
        mul_a     = diff;
        mul_b     = $signed({1'b0, sc_r});
        state_nxt = ST_X2;
      end
      ST_X2: begin
        mul_a     = $signed(prod_r[58:8]) + 51'sd16777216;
        mul_b     = $signed({12'b0, sw_r});
        state_nxt = ST_Y1;
      end
      ST_Y1: begin
        mul_a     = 51'(dy);
        mul_b     = $signed({1'b0, sc_r});
        state_nxt = ST_Y2;
      end
      ST_Y2: begin
        mul_a     = 51'sd16777216 - $signed(prod_r[50:0]);
        mul_b     = $signed({12'b0, sh_r});
        state_nxt = ST_H1;
      end
      ST_H1: begin
        mul_a     = $signed({35'b0, rw_r});
        mul_b     = $signed({1'b0, sc_r});
        state_nxt = ST_H2;
      end
      ST_H2: begin
        mul_a     = $signed(prod_r[50:0]);
        mul_b     = $signed({12'b0, sw_r});
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    // half width product is held while the result waits
    if (state_r != ST_FIN) begin
      prod_r <= mul_a * mul_b;
    end
    case (state_r)
      ST_IDLE: begin
        if (q.valid) begin
          item_r <= q.item;
        end
      end
      ST_DIV_INIT: begin
        den_r <= prod_r[24:0];
        rem_r <= '0;
        quo_r <= {cd_r, 16'b0};
        cnt_r <= '0;
        sc_r  <= SCALE_MAX;
      end
      ST_DIV: begin
        rem_r <= rem_ge ? 25'(rem_sh - {1'b0, den_r}) : rem_sh[24:0];
        quo_r <= {quo_r[30:0], rem_ge};
        cnt_r <= cnt_r + 5'd1;
      end
      ST_SAT: begin
        sc_r <= (quo_r[31:24] != '0) ? SCALE_MAX : quo_r[23:0];
      end
      ST_Y1: begin
        x_r <= sat16(prod_r[75:25]);
      end
      ST_H1: begin
        y_r <= sat16(prod_r[75:25]);
      end
      default: begin
      end
    endcase
    if (out_load) begin
      if (state_r == ST_FIN) begin
        out_data_r.visible         <= vis;
        out_data_r.screen_x        <= x_r;
        out_data_r.screen_y        <= y_r;
        out_data_r.half_width      <= hw;
        out_data_r.prev_x          <= last_x_r;
        out_data_r.prev_y          <= last_y_r;
        out_data_r.prev_half_width <= last_hw_r;
        out_data_r.clip_y          <= horizon_r;
        out_data_r.stripe          <= item_r.stripe;
      end else begin
        out_data_r <= '0;
      end
    end
  end

  // road state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sw_r        <= RST_SCREEN_WIDTH;
      sh_r        <= RST_SCREEN_HEIGHT;
      rw_r        <= RST_ROAD_WIDTH;
      sl_r        <= RST_SEGMENT_LENGTH;
      cd_r        <= RST_CAMERA_DEPTH;
      cam_x_r     <= '0;
      cam_h_r     <= '0;
      lat_off_r   <= '0;
      lat_step_r  <= '0;
      horizon_r   <= RST_SCREEN_HEIGHT;
      depth_r     <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_hw_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SCREEN_WIDTH:   sw_r <= cfg_data[12:0];
          CFG_SCREEN_HEIGHT:  sh_r <= cfg_data[12:0];
          CFG_ROAD_WIDTH:     rw_r <= cfg_data;
          CFG_SEGMENT_LENGTH: sl_r <= cfg_data[11:0];
          CFG_CAMERA_DEPTH:   cd_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (out_load && state_r == ST_FRAME) begin
        cam_x_r    <= item_r.camera_x;
        cam_h_r    <= item_r.camera_height;
        lat_off_r  <= '0;
        lat_step_r <= '0;
        horizon_r  <= sh_r;
        depth_r    <= '0;
        last_x_r   <= '0;
        last_y_r   <= '0;
        last_hw_r  <= '0;
      end
      if (out_load && state_r == ST_FIN) begin
        lat_off_r  <= sat32(off_sum);
        lat_step_r <= sat32(step_sum);
        if (vis) begin
          horizon_r <= y_r[15] ? 13'd0 : y_r[12:0];
        end
        if (depth_r != 13'h1FFF) begin
          depth_r <= depth_r + 13'd1;
        end
        last_x_r  <= x_r;
        last_y_r  <= y_r;
        last_hw_r <= hw;
      end
    end
  end

endmodule

/* design/road_segment_projector.sv */
// top level of the pseudo-3d road segment projector
//
//   channel  direction  signals
//   in       input      in_valid, in_ready, in_data (in_data_t)
//   out      output     out_valid, out_ready, out_data (out_data_t)
//   cfg      input      cfg_we, cfg_index, cfg_data
//
// a segment goes from queue to output register through the depth product, the
// 32-step radix-2 scale divider and the x, y and half-width passes through one
// shared multiplier; a zero-depth segment skips the divider
// synchronous active-low reset restores register defaults and clears the road state
// a two-entry queue keeps input transfers going while the back end works or
// the output register waits on out_ready
module road_segment_projector
  import rsp_pkg::*;
#(
  parameter int MAX_DRAW_SEGMENTS = MaxDrawSegmentsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_data_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_data_t   out_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rsp_queue_t q;
  logic       q_pop;

  rsp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q        (q),
    .q_pop    (q_pop)
  );

  rsp_back #(
    .MAX_DRAW_SEGMENTS (MAX_DRAW_SEGMENTS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q         (q),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* design/rsp_checker.sv */
// port-level checks for the road segment projector, bound to the top level
module rsp_checker
  import rsp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_data_t out_data
);

  // held result keeps its payload until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a visible segment lies above the horizon it was tested against
  a_vis_above_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |->
      $signed({out_data.screen_y[15], out_data.screen_y}) < $signed({4'b0, out_data.clip_y}))
    else $error("visible segment below horizon");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind road_segment_projector rsp_checker u_rsp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* sim/tb_top.sv */
// self-checking testbench for the road segment projector
module tb_top;
  import rsp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_data_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_data_t   out_data;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;

  road_segment_projector dut (.*);

  localparam longint ScaleTop = 64'hFFFFFF;
  localparam int DrawLimit = MaxDrawSegmentsDefault;

  // projector register copy
  longint scr_w, scr_h, road_w, seg_len, cam_depth;
  // road state copy
  longint lat_off, lat_step, horizon, depth_cnt;
  longint last_x, last_y, last_hw, cam_x, cam_h;

  out_data_t projected_q[$];
  int        errors;
  int        frames_sent, segments_sent, visible_seen, results_seen;
  int        hold_cycles;
  int        burst_left;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic longint clamp64(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  task automatic project_item(input in_data_t d);
    out_data_t r;
    longint den, sc, diff, p24, xv, yv, dy, hw;
    logic vis;
    r = '0;
    if (d.operation == OP_FRAME) begin
      cam_x = $signed(d.camera_x);
      cam_h = $signed(d.camera_height);
      lat_off = 0; lat_step = 0; horizon = scr_h; depth_cnt = 0;
      last_x = 0; last_y = 0; last_hw = 0;
      frames_sent++;
    end else begin
      den = depth_cnt * seg_len;
      sc = (den != 0) ? (cam_depth << 16) / den : ScaleTop;
      if (sc > ScaleTop) sc = ScaleTop;
      diff = lat_off - cam_x * 256;
      p24 = (sc * diff) >>> 8;
      xv = clamp64((scr_w * (longint'(1) << 24) + scr_w * p24) >>> 25, -32768, 32767);
      dy = longint'($signed(d.segment_height)) - cam_h;
      yv = clamp64((scr_h * ((longint'(1) << 24) - sc * dy)) >>> 25, -32768, 32767);
      hw = (sc * road_w * scr_w) >> 25;
      if (hw > 65535) hw = 65535;
      lat_off = clamp64(lat_off + lat_step, -(longint'(1) << 31), (longint'(1) << 31) - 1);
      lat_step = clamp64(lat_step + longint'($signed(d.segment_curve)),
                         -(longint'(1) << 31), (longint'(1) << 31) - 1);
      vis = depth_cnt != 0 && depth_cnt < DrawLimit && yv < horizon;
      r.visible = vis;
      r.screen_x = xv[15:0];
      r.screen_y = yv[15:0];
      r.half_width = hw[15:0];
      r.prev_x = last_x[15:0];
      r.prev_y = last_y[15:0];
      r.prev_half_width = last_hw[15:0];
      r.clip_y = horizon[12:0];
      r.stripe = ((d.segment_index / 3) % 2) != 0;
      if (vis) horizon = yv < 0 ? 0 : yv;
      last_x = xv; last_y = yv; last_hw = hw;
      if (depth_cnt < 8191) depth_cnt++;
      segments_sent++;
    end
    projected_q.insert(projected_q.size(), r);
  endtask

  // one input transfer; valid stays up into the next item unless a gap follows
  task automatic send_item(input in_data_t d);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (!in_ready);
    project_item(d);
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // write enable stays up across a run of writes and is dropped by the caller
  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_SCREEN_WIDTH:   scr_w = longint'(val[12:0]);
      CFG_SCREEN_HEIGHT:  scr_h = longint'(val[12:0]);
      CFG_ROAD_WIDTH:     road_w = longint'(val);
      CFG_SEGMENT_LENGTH: seg_len = longint'(val[11:0]);
      CFG_CAMERA_DEPTH:   cam_depth = longint'(val);
      default: ;
    endcase
  endtask

  task automatic set_regs(input int sw, sh, rw, sl, cd);
    write_reg(CFG_SCREEN_WIDTH, 16'(sw));
    write_reg(CFG_SCREEN_HEIGHT, 16'(sh));
    write_reg(CFG_ROAD_WIDTH, 16'(rw));
    write_reg(CFG_SEGMENT_LENGTH, 16'(sl));
    write_reg(CFG_CAMERA_DEPTH, 16'(cd));
    cfg_we <= 1'b0;
  endtask

  function automatic in_data_t frame_item(int cx, int ch);
    in_data_t d;
    d = '0;
    d.operation = OP_FRAME;
    d.camera_x = 24'(cx);
    d.camera_height = 24'(ch);
    d.segment_height = 24'($urandom);
    d.segment_curve = 12'($urandom);
    d.segment_index = 16'($urandom);
    return d;
  endfunction

  function automatic in_data_t segment_item(int sh, int cv, int idx);
    in_data_t d;
    d = '0;
    d.operation = OP_SEGMENT;
    d.camera_x = 24'($urandom);
    d.camera_height = 24'($urandom);
    d.segment_height = 24'(sh);
    d.segment_curve = 12'(cv);
    d.segment_index = 16'(idx);
    return d;
  endfunction

  function automatic in_data_t random_segment(int idx);
    if ($urandom_range(0, 7) == 0)
      return segment_item($urandom, $urandom, $urandom);
    return segment_item($urandom_range(0, 3000), $urandom_range(0, 160) - 80, idx);
  endfunction

  task automatic test_defaults;
    send_item(frame_item(0, 1500));
    for (int i = 0; i < 8; i++) send_item(segment_item(i * 40, 30, i));
    drain();
  endtask

  task automatic test_field_extremes;
    send_item(frame_item(24'sh7FFFFF, 24'sh7FFFFF));
    send_item(segment_item(24'sh800000, 12'sh7FF, 0));
    send_item(segment_item(24'sh7FFFFF, 12'sh800, 65535));
    send_item(segment_item(0, 12'sh7FF, 65534));
    send_item(frame_item(24'sh800000, 24'sh800000));
    send_item(segment_item(24'sh7FFFFF, 12'sh800, 3));
    send_item(segment_item(24'sh800000, 12'sh800, 5));
    send_item(segment_item(24'sh800000, 0, 6));
    // camera far above the road, segments project below the bottom of the screen
    send_item(frame_item(0, 24'sh7FFFFF));
    for (int i = 0; i < 4; i++) send_item(segment_item(-8000000, -5, i));
    send_item(frame_item(1000, 100));
    send_item(frame_item(-1000, 100));
    send_item(segment_item(100, 12'sh001, 7));
    send_item(segment_item(5000, 12'sh001, 8));
    send_item(segment_item(50, 12'sh001, 9));
    drain();
  endtask

  task automatic test_register_sweep;
    set_regs(1, 1, 1, 1, 1);
    send_item(frame_item(5, 200));
    for (int i = 0; i < 6; i++) send_item(random_segment(i));
    drain();
    set_regs(4096, 4096, 65535, 4095, 65535);
    send_item(frame_item(-300, 900));
    for (int i = 0; i < 6; i++) send_item(random_segment(i));
    drain();
    set_regs(4096, 4096, 65535, 1, 65535);
    send_item(frame_item(7000, 30000));
    for (int i = 0; i < 6; i++) send_item(random_segment(i));
    drain();
  endtask

  task automatic test_draw_distance;
    set_regs(640, 480, 2000, 20, 215);
    send_item(frame_item(0, 1000));
    for (int i = 0; i < 530; i++) send_item(segment_item(i, $urandom_range(0, 20) - 10, i));
    drain();
  endtask

  task automatic test_backpressure;
    hold_cycles = 600;
    burst_left = 40;
    send_item(frame_item(0, 1200));
    for (int i = 0; i < 12; i++) send_item(random_segment(i));
    drain();
  endtask

  task automatic test_random_frames(input int n_items);
    int sent, seg_n, base;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 4) == 0) begin
        drain();
        set_regs($urandom_range(1, 4096), $urandom_range(1, 4096), $urandom_range(1, 65535),
                 $urandom_range(1, 4095), $urandom_range(1, 65535));
      end
      if ($urandom_range(0, 7) == 0)
        send_item(frame_item($urandom, $urandom));
      else
        send_item(frame_item($urandom_range(0, 4000) - 2000, $urandom_range(500, 6000)));
      seg_n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 3) : $urandom_range(5, 60);
      base = $urandom_range(0, 65535);
      for (int i = 0; i < seg_n; i++) send_item(random_segment(base + i));
      sent += seg_n + 1;
    end
    drain();
  endtask

  task automatic check_field(input string name, input longint e, input longint a);
    if (e != a) begin
      $error("%s mismatch: expected %0d, got %0d", name, e, a);
      errors++;
    end
  endtask

  // result checking and receiver stall pattern
  int stall_phase;
  always @(posedge clk) begin
    out_data_t e;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (projected_q.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = projected_q.pop_front();
        if (out_data.visible) visible_seen++;
        check_field("visible", longint'(e.visible), longint'(out_data.visible));
        check_field("screen_x", longint'(e.screen_x), longint'(out_data.screen_x));
        check_field("screen_y", longint'(e.screen_y), longint'(out_data.screen_y));
        check_field("half_width", longint'(e.half_width), longint'(out_data.half_width));
        check_field("prev_x", longint'(e.prev_x), longint'(out_data.prev_x));
        check_field("prev_y", longint'(e.prev_y), longint'(out_data.prev_y));
        check_field("prev_half_width", longint'(e.prev_half_width),
                    longint'(out_data.prev_half_width));
        check_field("clip_y", longint'(e.clip_y), longint'(out_data.clip_y));
        check_field("stripe", longint'(e.stripe), longint'(out_data.stripe));
      end
    end
    stall_phase = (stall_phase + 1) % 512;
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else if (stall_phase < 200) begin
      out_ready <= 1'b1;
    end else if (stall_phase < 350) begin
      out_ready <= $urandom_range(0, 2) != 0;
    end else begin
      out_ready <= ($urandom_range(0, 5) == 0) || (stall_phase % 97 > 40);
    end
  end

  initial begin
    #8_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin
    errors = 0; frames_sent = 0; segments_sent = 0; visible_seen = 0; results_seen = 0;
    hold_cycles = 0; burst_left = 0; stall_phase = 0;
    scr_w = RST_SCREEN_WIDTH; scr_h = RST_SCREEN_HEIGHT; road_w = RST_ROAD_WIDTH;
    seg_len = RST_SEGMENT_LENGTH; cam_depth = RST_CAMERA_DEPTH;
    lat_off = 0; lat_step = 0; horizon = scr_h; depth_cnt = 0;
    last_x = 0; last_y = 0; last_hw = 0; cam_x = 0; cam_h = 0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_ready <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_field_extremes();
    test_register_sweep();
    test_draw_distance();
    test_backpressure();
    set_regs(1024, 768, 2000, 200, 215);
    test_random_frames(1250);
    $display("covered %0d frame starts and %0d segments, %0d results checked, %0d visible",
             frames_sent, segments_sent, results_seen, visible_seen);
    $display("register sweeps at both extremes, draw-distance frame and long output stall");
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
design/rsp_pkg.sv
design/rsp_front.sv
design/rsp_back.sv
design/road_segment_projector.sv
design/rsp_checker.sv
sim/tb_top.sv
